### rtl/pca_pkg.sv
// Shared types, constants and helpers of the path channel admission unit.
`timescale 1ns / 1ps

package pca_pkg;

  localparam int LINK_W   = 6;
  localparam int NODE_W   = 4;
  localparam int HOP_W    = 4;
  localparam int BUSY_W   = 8;
  localparam int CNT_W    = 32;
  localparam int CFG_W    = 8;
  localparam int CFG_AW   = 3;
  localparam int IN_DW    = 64;
  localparam int OUT_DW   = 96;
  localparam int OUT_UW   = 2;

  // in_tdata field positions
  localparam int SRC_LSB  = 0;
  localparam int DST_LSB  = 4;
  localparam int HOPS_LSB = 8;
  localparam int LINK_LSB = 12;

  localparam logic REG_CHANNELS = 1'b0;
  localparam logic [CFG_W-1:0] CHANNELS_RST = 8'd16;

  typedef enum logic {
    KIND_ARRIVAL = 1'b0,
    KIND_DEPART  = 1'b1
  } pca_kind_t;

  typedef enum logic [1:0] {
    OUT_ADMIT   = 2'd0,
    OUT_BLOCK   = 2'd1,
    OUT_RELEASE = 2'd2
  } pca_outcome_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_DISP,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_CHK_END,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_PAIR_RD,
    ST_OUT
  } pca_state_t;

  typedef struct packed {
    logic clr;         // clearing pass write
    logic item_start;  // transaction accepted
    logic lnk_rd;      // read link busy count
    logic lnk_chk;     // compare link count against capacity
    logic lnk_wr;      // write updated link count
    logic pair_rd;     // read pair counters
    logic commit;      // write counters, load result register
  } pca_ctl_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

### rtl/pca_ctrl.sv
// Sequencer: clearing pass, per-hop check and update steps, result hand-off.
`timescale 1ns / 1ps

module pca_ctrl #(
  parameter int MAX_HOPS  = 8,
  parameter int CLR_DEPTH = 256,
  localparam int HIW = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1,
  localparam int CW  = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_accept,
  input  pca_pkg::pca_kind_t        kind,
  input  logic [pca_pkg::HOP_W-1:0] hops,
  input  logic                      fail,
  input  logic                      out_free,
  output logic                      in_ready,
  output pca_pkg::pca_ctl_t         ctl,
  output logic [HIW-1:0]            hop_idx,
  output logic [CW-1:0]             clr_addr
);

  pca_pkg::pca_state_t state_r, state_nxt;
  logic [HIW-1:0] hop_r, hop_nxt;
  logic [CW-1:0]  clr_r, clr_nxt;
  logic           last_hop;
  logic           clr_last;

  assign last_hop = (pca_pkg::HOP_W'(hop_r) + pca_pkg::HOP_W'(1)) == hops;
  assign clr_last = clr_r == CW'(CLR_DEPTH - 1);
  assign hop_idx  = hop_r;
  assign clr_addr = clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pca_pkg::ST_CLR;
      hop_r   <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      hop_r   <= hop_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pca_pkg::ST_CLR:     if (clr_last) state_nxt = pca_pkg::ST_IDLE;
      pca_pkg::ST_IDLE:    if (in_accept) state_nxt = pca_pkg::ST_DISP;
      pca_pkg::ST_DISP: begin
        if (hops == '0) state_nxt = pca_pkg::ST_PAIR_RD;
        else if (kind == pca_pkg::KIND_ARRIVAL) state_nxt = pca_pkg::ST_CHK_RD;
        else state_nxt = pca_pkg::ST_UPD_RD;
      end
      pca_pkg::ST_CHK_RD:  state_nxt = pca_pkg::ST_CHK_CMP;
      pca_pkg::ST_CHK_CMP: state_nxt = last_hop ? pca_pkg::ST_CHK_END : pca_pkg::ST_CHK_RD;
      pca_pkg::ST_CHK_END: state_nxt = fail ? pca_pkg::ST_PAIR_RD : pca_pkg::ST_UPD_RD;
      pca_pkg::ST_UPD_RD:  state_nxt = pca_pkg::ST_UPD_WR;
      pca_pkg::ST_UPD_WR:  state_nxt = last_hop ? pca_pkg::ST_PAIR_RD : pca_pkg::ST_UPD_RD;
      pca_pkg::ST_PAIR_RD: state_nxt = pca_pkg::ST_OUT;
      pca_pkg::ST_OUT:     if (out_free) state_nxt = pca_pkg::ST_IDLE;
      default:             state_nxt = pca_pkg::ST_CLR;
    endcase
  end

  // hop and clear counters
  always_comb begin
    hop_nxt = hop_r;
    clr_nxt = clr_r;
    case (state_r) inside
      pca_pkg::ST_CLR:                        clr_nxt = clr_r + CW'(1);
      pca_pkg::ST_IDLE, pca_pkg::ST_CHK_END:  hop_nxt = '0;
      pca_pkg::ST_CHK_CMP, pca_pkg::ST_UPD_WR: begin
        if (!last_hop) hop_nxt = hop_r + HIW'(1);
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state_r) inside
      pca_pkg::ST_CLR:     ctl.clr = 1'b1;
      pca_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        ctl.item_start = in_accept;
      end
      pca_pkg::ST_CHK_RD,
      pca_pkg::ST_UPD_RD:  ctl.lnk_rd = 1'b1;
      pca_pkg::ST_CHK_CMP: ctl.lnk_chk = 1'b1;
      pca_pkg::ST_UPD_WR:  ctl.lnk_wr = 1'b1;
      pca_pkg::ST_PAIR_RD: ctl.pair_rd = 1'b1;
      pca_pkg::ST_OUT:     ctl.commit = out_free;
      pca_pkg::ST_DISP,
      pca_pkg::ST_CHK_END: ;
      default: ;
    endcase
  end

endmodule

### rtl/pca_link_unit.sv
// Link busy-count memory with the shared compare and step-by-one unit.
`timescale 1ns / 1ps

module pca_link_unit #(
  parameter int MAX_LINKS = 64,
  parameter int CW        = 8,
  localparam int LAW = $clog2(MAX_LINKS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pca_pkg::pca_ctl_t          ctl,
  input  pca_pkg::pca_kind_t         kind,
  input  logic [pca_pkg::LINK_W-1:0] link_sel,
  input  logic [pca_pkg::CFG_W-1:0]  channels,
  input  logic [CW-1:0]              clr_addr,
  output logic                       fail
);

  logic [pca_pkg::BUSY_W-1:0] mem [MAX_LINKS];
  logic [pca_pkg::BUSY_W-1:0] rd_r;
  logic [pca_pkg::BUSY_W-1:0] step;
  logic [pca_pkg::BUSY_W-1:0] wdata;
  logic [LAW-1:0]             addr;
  logic [LAW-1:0]             waddr;
  logic                       in_range;
  logic                       sat;
  logic                       we;
  logic                       fail_r, fail_nxt;

  assign in_range = 32'(link_sel) < MAX_LINKS;
  assign addr     = LAW'(link_sel);

  // one adder serves increment (arrival) and decrement (departure)
  assign step  = (kind == pca_pkg::KIND_ARRIVAL) ? pca_pkg::BUSY_W'(1) : '1;
  assign sat   = (kind == pca_pkg::KIND_ARRIVAL) ? (rd_r == '1) : (rd_r == '0);
  assign wdata = ctl.clr ? '0 : (sat ? rd_r : rd_r + step);
  assign waddr = ctl.clr ? LAW'(clr_addr) : addr;
  assign we    = ctl.clr ? (32'(clr_addr) < MAX_LINKS) : (ctl.lnk_wr && in_range);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (ctl.lnk_rd) rd_r <= mem[addr];
  end

  always_comb begin
    fail_nxt = fail_r;
    if (ctl.item_start) fail_nxt = 1'b0;
    else if (ctl.lnk_chk && (!in_range || rd_r >= channels)) fail_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fail_r <= 1'b0;
    else fail_r <= fail_nxt;
  end

  assign fail = fail_r;

endmodule

### rtl/pca_pair_cnt.sv
// Per source-destination pair attempt and block counters.
`timescale 1ns / 1ps

module pca_pair_cnt #(
  parameter int MAX_NODES = 16,
  parameter int CW        = 8,
  localparam int NPAIRS = MAX_NODES * MAX_NODES,
  localparam int PAW    = $clog2(NPAIRS)
) (
  input  logic                      clk,
  input  pca_pkg::pca_ctl_t         ctl,
  input  logic [PAW-1:0]            pair,
  input  logic                      pair_ok,
  input  logic                      arrival,
  input  logic                      blocked,
  input  logic [CW-1:0]             clr_addr,
  output logic [pca_pkg::CNT_W-1:0] attempts,
  output logic [pca_pkg::CNT_W-1:0] blocks
);

  logic [pca_pkg::CNT_W-1:0] att_mem [NPAIRS];
  logic [pca_pkg::CNT_W-1:0] blk_mem [NPAIRS];
  logic [pca_pkg::CNT_W-1:0] att_r, blk_r;
  logic [pca_pkg::CNT_W-1:0] att_new, blk_new;
  logic [PAW-1:0]            waddr;
  logic                      we;

  assign att_new = arrival ? pca_pkg::sat_inc(att_r) : att_r;
  assign blk_new = blocked ? pca_pkg::sat_inc(blk_r) : blk_r;

  assign waddr = ctl.clr ? PAW'(clr_addr) : pair;
  assign we    = ctl.clr ? (32'(clr_addr) < NPAIRS) : (ctl.commit && pair_ok && arrival);

  always_ff @(posedge clk) begin
    if (we) begin
      att_mem[waddr] <= ctl.clr ? '0 : att_new;
      blk_mem[waddr] <= ctl.clr ? '0 : blk_new;
    end
    if (ctl.pair_rd) begin
      att_r <= att_mem[pair];
      blk_r <= blk_mem[pair];
    end
  end

  assign attempts = pair_ok ? att_new : '0;
  assign blocks   = pair_ok ? blk_new : '0;

endmodule

### rtl/path_channel_admission_unit.sv
// Top level of the path channel admission unit.
`timescale 1ns / 1ps
//
// Channel  Dir  Handshake                  Payload
// in       in   in_tvalid / in_tready      tuser: kind; tdata: nodes, hops, links
// out      out  out_tvalid / out_tready    tuser: outcome; tdata: three counters
// cfg      in   APB psel/penable/pwrite    reg 0 @ 0x0: channels_per_link [7:0]
//
// One transaction at a time: in_tready is high only while the sequencer idles.
// Link work runs through one link memory and one compare/step unit, a read
// step then a compare or write step per hop. Arrivals check every hop, then
// step the counts up if none is full; departures only step them down; empty routes skip link work.
// After reset a clearing pass over max(MAX_LINKS, MAX_NODES^2) addresses (256 by
// default) zeroes the link and pair memories; in_tready stays low meanwhile.
// A result waits in the output register while out_tready is low; the next
// transaction may be accepted but is not finished until that register frees.

module path_channel_admission_unit #(
  parameter int MAX_LINKS = 64,
  parameter int MAX_NODES = 16,
  parameter int MAX_HOPS  = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input transactions
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [0] kind
  input  logic [0:0]                  in_tuser,
  // [3:0] source_node, [7:4] dest_node, [11:8] hop_count,
  // [17:12] link_0 .. [59:54] link_7, [63:60] zero
  input  logic [pca_pkg::IN_DW-1:0]   in_tdata,
  // result transactions
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [1:0] outcome
  output logic [pca_pkg::OUT_UW-1:0]  out_tuser,
  // [31:0] pair_attempts, [63:32] pair_blocks, [95:64] total_blocks
  output logic [pca_pkg::OUT_DW-1:0]  out_tdata,
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pca_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int NPAIRS    = MAX_NODES * MAX_NODES;
  localparam int PAW       = $clog2(NPAIRS);
  localparam int CLR_DEPTH = (MAX_LINKS > NPAIRS) ? MAX_LINKS : NPAIRS;
  localparam int CW        = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
  localparam int HIW       = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;

  // configuration register
  logic [pca_pkg::CFG_W-1:0] channels_r;
  logic                      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[2] == pca_pkg::REG_CHANNELS);
  assign cfg_prdata = (cfg_paddr[2] == pca_pkg::REG_CHANNELS) ?
                      32'(channels_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) channels_r <= pca_pkg::CHANNELS_RST;
    else if (cfg_wr) channels_r <= cfg_pwdata[pca_pkg::CFG_W-1:0];
  end

  // captured transaction
  logic                        in_accept;
  pca_pkg::pca_kind_t          kind_r;
  logic [PAW-1:0]              pair_r;
  logic                        pair_ok_r;
  logic [pca_pkg::HOP_W-1:0]   hops_r;
  logic [pca_pkg::LINK_W-1:0]  links_r [MAX_HOPS];
  logic [pca_pkg::NODE_W-1:0]  src_in, dst_in;
  logic [pca_pkg::HOP_W-1:0]   hops_in, hops_clip;

  assign in_accept = in_tvalid && in_tready;
  assign src_in  = in_tdata[pca_pkg::SRC_LSB +: pca_pkg::NODE_W];
  assign dst_in  = in_tdata[pca_pkg::DST_LSB +: pca_pkg::NODE_W];
  assign hops_in = in_tdata[pca_pkg::HOPS_LSB +: pca_pkg::HOP_W];
  // routes longer than the hop limit are cut to it
  assign hops_clip = (32'(hops_in) > MAX_HOPS) ? pca_pkg::HOP_W'(MAX_HOPS) : hops_in;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r    <= pca_pkg::pca_kind_t'(in_tuser[0]);
      hops_r    <= hops_clip;
      pair_ok_r <= (32'(src_in) < MAX_NODES) && (32'(dst_in) < MAX_NODES);
      pair_r    <= PAW'(32'(src_in) * MAX_NODES + 32'(dst_in));
    end
  end

  for (genvar g = 0; g < MAX_HOPS; g++) begin : g_link
    always_ff @(posedge clk) begin
      if (in_accept)
        links_r[g] <= in_tdata[pca_pkg::LINK_LSB + g*pca_pkg::LINK_W +: pca_pkg::LINK_W];
    end
  end

  // sequencer
  pca_pkg::pca_ctl_t ctl;
  logic [HIW-1:0]    hop_idx;
  logic [CW-1:0]     clr_addr;
  logic              fail;
  logic              out_free;

  assign out_free = !out_tvalid || out_tready;

  pca_ctrl #(
    .MAX_HOPS  (MAX_HOPS),
    .CLR_DEPTH (CLR_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .kind      (kind_r),
    .hops      (hops_r),
    .fail      (fail),
    .out_free  (out_free),
    .in_ready  (in_tready),
    .ctl       (ctl),
    .hop_idx   (hop_idx),
    .clr_addr  (clr_addr)
  );

  pca_link_unit #(
    .MAX_LINKS (MAX_LINKS),
    .CW        (CW)
  ) u_link (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .kind     (kind_r),
    .link_sel (links_r[hop_idx]),
    .channels (channels_r),
    .clr_addr (clr_addr),
    .fail     (fail)
  );

  // counters
  logic                      arrival;
  logic                      blocked;
  logic [pca_pkg::CNT_W-1:0] attempts, blocks;
  logic [pca_pkg::CNT_W-1:0] total_r, total_nxt;

  assign arrival = kind_r == pca_pkg::KIND_ARRIVAL;
  assign blocked = arrival && fail;

  pca_pair_cnt #(
    .MAX_NODES (MAX_NODES),
    .CW        (CW)
  ) u_pair (
    .clk      (clk),
    .ctl      (ctl),
    .pair     (pair_r),
    .pair_ok  (pair_ok_r),
    .arrival  (arrival),
    .blocked  (blocked),
    .clr_addr (clr_addr),
    .attempts (attempts),
    .blocks   (blocks)
  );

  assign total_nxt = blocked ? pca_pkg::sat_inc(total_r) : total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) total_r <= '0;
    else if (ctl.commit) total_r <= total_nxt;
  end

  // result register
  pca_pkg::pca_outcome_t outcome;
  logic                  out_tvalid_r, out_tvalid_nxt;

  always_comb begin
    if (!arrival) outcome = pca_pkg::OUT_RELEASE;
    else if (fail) outcome = pca_pkg::OUT_BLOCK;
    else outcome = pca_pkg::OUT_ADMIT;
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (ctl.commit) out_tvalid_nxt = 1'b1;
    else if (out_tready) out_tvalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else out_tvalid_r <= out_tvalid_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_tuser <= outcome;
      out_tdata <= {total_nxt, blocks, attempts};
    end
  end

  assign out_tvalid = out_tvalid_r;

endmodule

### rtl/pca_checker.sv
// Port-level checker for the path channel admission unit, bound to the top.
`timescale 1ns / 1ps

module pca_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [pca_pkg::OUT_UW-1:0]  out_tuser,
  input logic [pca_pkg::OUT_DW-1:0]  out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one transaction in flight: accepted item closes the input side
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // a blocked arrival is always reflected in the total
  a_block_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == pca_pkg::OUT_BLOCK |-> out_tdata[95:64] != '0)
    else $error("blocked result with zero total");

  // pair blocks never exceed pair attempts
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[63:32] <= out_tdata[31:0])
    else $error("pair blocks above pair attempts");

endmodule

bind path_channel_admission_unit pca_checker u_pca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);
